>>> src/mss_pkg.sv
package mss_pkg;

    // Width of the station fields in the result.
    localparam int unsigned STN_W = 4;

    // Wait period numerator: milliseconds in one minute.
    localparam logic [15:0] MS_PER_MINUTE = 16'd60000;
    localparam int unsigned QUO_W = 16;
    // Divisor is cycles_per_minute times enabled stations: at most 255 * 16.
    localparam int unsigned DEN_W = 12;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;

    localparam logic [1:0] SERVO_NONE     = 2'd0;
    localparam logic [1:0] SERVO_HOME_ALL = 2'd1;
    localparam logic [1:0] SERVO_START    = 2'd2;
    localparam logic [1:0] SERVO_HOME     = 2'd3;

    localparam logic [2:0] CFG_KEY_TH  = 3'd0;
    localparam logic [2:0] CFG_STR_TH  = 3'd1;
    localparam logic [2:0] CFG_FAIL_LM = 3'd2;
    localparam logic [2:0] CFG_ROT_ST  = 3'd3;
    localparam logic [2:0] CFG_ROT_HM  = 3'd4;
    localparam logic [2:0] CFG_CPM     = 3'd5;

    typedef enum logic [2:0] {
        RUN_STOPPED   = 3'd0,
        RUN_ESTOP     = 3'd1,
        RUN_READY     = 3'd2,
        RUN_ACTUATING = 3'd3,
        RUN_WAITING   = 3'd4
    } t_run;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_COUNT,
        SEQ_LOAD,
        SEQ_DIV,
        SEQ_EXEC
    } t_seq;

    typedef struct packed {
        logic [1:0]  cmd;
        logic        estop_level;
        logic [15:0] keyswitch_peak_ma;
        logic [15:0] starter_peak_ma;
    } t_in_item;

    typedef struct packed {
        logic [2:0]       run_state;
        logic [1:0]       servo_action;
        logic [STN_W-1:0] servo_station;
        logic             calibrate_pulse;
        logic             reset_peaks_pulse;
        logic             track_peaks_pulse;
        logic             report_valid;
        logic [STN_W-1:0] report_station;
        logic             report_enabled;
        logic [31:0]      report_cycles;
        logic [15:0]      report_failures;
        logic             cmd_accepted;
    } t_out_item;

endpackage

>>> src/mss_div.sv
module mss_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [mss_pkg::DEN_W-1:0] i_den,
    output logic                      o_done,
    output logic [mss_pkg::QUO_W-1:0] o_quo
);
    import mss_pkg::*;

    // Restoring division of the fixed numerator, one quotient bit a cycle.
    logic                 r_busy;
    logic                 r_done;
    logic [3:0]           r_cnt;
    logic [DEN_W-1:0]     r_den;
    logic [DEN_W-1:0]     r_rem;
    logic [QUO_W-1:0]     r_quo;
    logic [DEN_W:0]       rem_sh;
    logic [DEN_W:0]       rem_diff;
    logic                 q_bit;

    assign rem_sh   = {r_rem, r_quo[QUO_W-1]};
    assign rem_diff = rem_sh - {1'b0, r_den};
    assign q_bit    = (rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'(QUO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= MS_PER_MINUTE;
        end else if (r_busy) begin
            r_rem <= q_bit ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], q_bit};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

>>> src/multi_station_switch_test_sequencer_top.sv
// Channel   Direction  Handshake              Payload
// in        input      i_in_valid/o_in_stall  i_in_data  (mss_pkg::t_in_item)
// out       output     o_out_valid/i_out_stall o_out_data (mss_pkg::t_out_item)
// cfg       input      i_cfg_we               i_cfg_idx, i_cfg_data
//
// Each accepted item passes through the sequencer states in order: SEQ_COUNT counts the
// enabled stations, SEQ_LOAD loads the divisor, SEQ_DIV runs the restoring divider (sixteen
// quotient bits and its done flag) that gives the wait period, and SEQ_EXEC updates the
// state and the output register. A new item is accepted only in SEQ_IDLE, after the update.
// Reset is synchronous and active low; all stations come up enabled with zeroed counts.
// A stalled result stays in the output register; the next item is accepted meanwhile.
module multi_station_switch_test_sequencer_top #(
    parameter int unsigned STATIONS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  mss_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mss_pkg::t_out_item o_out_data,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data
);
    import mss_pkg::*;

    localparam int unsigned SIW = (STATIONS > 1) ? $clog2(STATIONS) : 1;
    localparam int unsigned NW  = $clog2(STATIONS + 1);

    // Configuration.
    logic [15:0] r_key_th;
    logic [15:0] r_str_th;
    logic [15:0] r_fail_lm;
    logic [15:0] r_rot_st;
    logic [15:0] r_rot_hm;
    logic [7:0]  r_cpm;

    // Sequencer.
    t_seq             r_seq;
    t_seq             n_seq;
    t_in_item         r_in;
    logic [SIW-1:0]   r_idx;
    logic [NW-1:0]    r_nen;
    logic             div_start;
    logic             div_done;
    logic [QUO_W-1:0] div_quo;
    logic             in_xfer;
    logic             out_free;
    logic             commit;

    // Block state.
    t_run           r_run;
    t_run           n_run;
    t_run           run_t;
    logic [SIW-1:0] r_act;
    logic [SIW-1:0] n_act;
    logic [SIW-1:0] act_nxt;
    logic [31:0]    r_elapsed;
    logic [31:0]    n_elapsed;
    logic [31:0]    el_inc;
    logic [31:0]    r_cyc  [STATIONS];
    logic [15:0]    r_fail [STATIONS];
    logic [STATIONS-1:0] r_en;

    logic        running;
    logic        stn_we;
    logic [31:0] cyc_new;
    logic [15:0] fail_new;
    logic        en_new;
    logic [QUO_W-1:0] wait_ms;

    t_out_item r_out;
    t_out_item res;
    logic      r_out_valid;

    assign in_xfer    = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_seq != SEQ_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign commit     = (r_seq == SEQ_EXEC) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_th  <= 16'd0;
            r_str_th  <= 16'd0;
            r_fail_lm <= 16'd10;
            r_rot_st  <= 16'd500;
            r_rot_hm  <= 16'd500;
            r_cpm     <= 8'd6;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KEY_TH:  r_key_th  <= i_cfg_data;
                CFG_STR_TH:  r_str_th  <= i_cfg_data;
                CFG_FAIL_LM: r_fail_lm <= i_cfg_data;
                CFG_ROT_ST:  r_rot_st  <= i_cfg_data;
                CFG_ROT_HM:  r_rot_hm  <= i_cfg_data;
                CFG_CPM:     r_cpm     <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Sequencer state register and next state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= SEQ_IDLE;
        end else begin
            r_seq <= n_seq;
        end
    end

    always_comb begin
        n_seq     = r_seq;
        div_start = 1'b0;
        unique case (r_seq)
            SEQ_IDLE: begin
                if (in_xfer) n_seq = SEQ_COUNT;
            end
            SEQ_COUNT: begin
                if (r_idx == SIW'(STATIONS - 1)) n_seq = SEQ_LOAD;
            end
            SEQ_LOAD: begin
                div_start = 1'b1;
                n_seq     = SEQ_DIV;
            end
            SEQ_DIV: begin
                if (div_done) n_seq = SEQ_EXEC;
            end
            SEQ_EXEC: begin
                if (out_free) n_seq = SEQ_IDLE;
            end
            default: n_seq = SEQ_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in  <= i_in_data;
            r_idx <= '0;
            r_nen <= '0;
        end else if (r_seq == SEQ_COUNT) begin
            r_nen <= r_nen + NW'(r_en[r_idx]);
            if (r_idx != SIW'(STATIONS - 1)) r_idx <= r_idx + 1'b1;
        end
    end

    mss_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_den   (DEN_W'(r_cpm) * DEN_W'(r_nen)),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign wait_ms = (r_nen == '0 || r_cpm == 8'd0) ? '0 : div_quo;
    assign running = (r_run == RUN_READY) || (r_run == RUN_ACTUATING) ||
                     (r_run == RUN_WAITING);
    assign act_nxt = (r_act == SIW'(STATIONS - 1)) ? '0 : r_act + 1'b1;
    assign el_inc  = (r_elapsed != 32'hFFFF_FFFF) ? r_elapsed + 32'd1 : r_elapsed;
    assign cyc_new = r_cyc[r_act] + 32'd1;
    assign fail_new = ((r_in.keyswitch_peak_ma < r_key_th ||
                        r_in.starter_peak_ma < r_str_th) && r_fail[r_act] != 16'hFFFF) ?
                      r_fail[r_act] + 16'd1 : r_fail[r_act];
    assign en_new  = r_en[r_act] && !(fail_new >= r_fail_lm);

    // One step of the station state machine for the held item.
    always_comb begin
        res       = '0;
        n_run     = r_run;
        n_act     = r_act;
        n_elapsed = r_elapsed;
        stn_we    = 1'b0;
        run_t     = r_run;
        unique case (r_in.cmd)
            CMD_START: begin
                if (!running && !r_in.estop_level) begin
                    n_run            = RUN_READY;
                    res.cmd_accepted = 1'b1;
                end
            end
            CMD_STOP: begin
                if (running) begin
                    n_run            = RUN_STOPPED;
                    res.cmd_accepted = 1'b1;
                end
            end
            CMD_TICK: begin
                if (r_run == RUN_ACTUATING || r_run == RUN_WAITING) n_elapsed = el_inc;
                if (r_in.estop_level && r_run != RUN_ESTOP) begin
                    run_t = RUN_ESTOP;
                end else if (!r_in.estop_level && r_run == RUN_ESTOP) begin
                    run_t = RUN_STOPPED;
                end
                n_run = run_t;
                unique case (run_t)
                    RUN_READY: begin
                        if (r_en[r_act]) begin
                            n_elapsed             = '0;
                            res.calibrate_pulse   = 1'b1;
                            res.reset_peaks_pulse = 1'b1;
                            n_run                 = RUN_ACTUATING;
                        end else begin
                            n_act = act_nxt;
                        end
                    end
                    RUN_ACTUATING: begin
                        res.track_peaks_pulse = 1'b1;
                        if (n_elapsed <= 32'(r_rot_st)) begin
                            res.servo_action  = SERVO_START;
                            res.servo_station = STN_W'(r_act);
                        end else if (n_elapsed <= 32'(r_rot_st) + 32'(r_rot_hm)) begin
                            res.servo_action  = SERVO_HOME;
                            res.servo_station = STN_W'(r_act);
                        end else begin
                            stn_we              = 1'b1;
                            res.report_valid    = 1'b1;
                            res.report_station  = STN_W'(r_act);
                            res.report_enabled  = en_new;
                            res.report_cycles   = cyc_new;
                            res.report_failures = fail_new;
                            n_act               = act_nxt;
                            n_run               = RUN_WAITING;
                        end
                    end
                    RUN_WAITING: begin
                        if (n_elapsed > 32'(wait_ms)) n_run = RUN_READY;
                    end
                    default: begin
                        n_run            = (run_t == RUN_ESTOP) ? RUN_ESTOP : RUN_STOPPED;
                        res.servo_action = SERVO_HOME_ALL;
                    end
                endcase
            end
            default: ;
        endcase
        res.run_state = n_run;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run     <= RUN_STOPPED;
            r_act     <= '0;
            r_elapsed <= '0;
            r_en      <= '1;
            for (int i = 0; i < STATIONS; i++) begin
                r_cyc[i]  <= '0;
                r_fail[i] <= '0;
            end
        end else if (commit) begin
            r_run     <= n_run;
            r_act     <= n_act;
            r_elapsed <= n_elapsed;
            if (stn_we) begin
                r_cyc[r_act]  <= cyc_new;
                r_fail[r_act] <= fail_new;
                r_en[r_act]   <= en_new;
            end
        end
    end

    // Output register: holds a stalled result while the next item is worked on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) r_out <= res;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_report_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.report_valid) |->
            (o_out_data.run_state == RUN_WAITING))
        else $error("cycle report outside the waiting state");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> o_in_stall)
        else $error("sequencer did not start on an accepted transfer");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_seq == SEQ_DIV))
        else $error("divider finished outside its sequencer phase");

    a_calib_starts_act: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.calibrate_pulse) |->
            (o_out_data.run_state == RUN_ACTUATING &&
             o_out_data.servo_action == SERVO_NONE))
        else $error("calibration request without an actuation start");

endmodule
